FILE: rtl/mts_pkg.sv
// Shared types, constants and helper functions of the mosaic tile scale addresser.
package mts_pkg;

   localparam int MaxDim  = 4096;
   localparam int MaxGrid = 16;
   localparam int DimW    = 13;
   localparam int PosW    = 12;
   localparam int GridW   = 5;
   localparam int IdxW    = 4;
   localparam int PageW   = 8;
   localparam int RcW     = 9;
   localparam int FrameW  = 16;
   localparam int NumW    = 25;
   localparam int Steps   = 25;
   localparam int CsrW    = 3;

   typedef enum logic [CsrW-1:0] {
      REG_GRID_COLS  = 3'd0,
      REG_GRID_ROWS  = 3'd1,
      REG_START_PAGE = 3'd2,
      REG_OUT_WIDTH  = 3'd3,
      REG_OUT_HEIGHT = 3'd4,
      REG_SRC_WIDTH  = 3'd5,
      REG_SRC_HEIGHT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [PosW-1:0] out_x;
      logic [PosW-1:0] out_y;
      logic            mode;
   } req_type;

   typedef struct packed {
      logic [FrameW-1:0] frame_index;
      logic [PosW-1:0]   src_x;
      logic [PosW-1:0]   src_y;
   } rsp_type;

   typedef struct packed {
      logic [DimW-1:0] rem;
      logic [NumW-1:0] numq;
      logic [DimW-1:0] divisor;
   } lane_type;

   typedef struct packed {
      lane_type lx;
      lane_type ly;
   } pair_type;

   typedef struct packed {
      logic              valid;
      logic [PosW-1:0]   out_x;
      logic [PosW-1:0]   out_y;
      logic              mode;
      logic [IdxW-1:0]   col;
      logic [IdxW-1:0]   row;
      logic [RcW-1:0]    rc;
      logic [FrameW-1:0] frame;
   } ctx_type;

   function automatic logic [GridW-1:0] clamp_grid(input logic [GridW-1:0] v);
      logic [GridW-1:0] r;
      r = v;
      if (v == '0) r = GridW'(1);
      else if (v > GridW'(MaxGrid)) r = GridW'(MaxGrid);
      return r;
   endfunction

   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
      logic [DimW-1:0] r;
      r = v;
      if (v < DimW'(2)) r = DimW'(2);
      else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
      return r;
   endfunction

   function automatic logic [DimW-1:0] half_src(input logic [DimW-1:0] v, input logic half);
      return half ? (v >> 1) : v;
   endfunction

endpackage

FILE: rtl/mosaic_tile_scale_addresser.sv
// Top level of the mosaic tile scale addresser: registers, pipeline stages and result register.
// Takes one beat per clock unless a stalled result holds the pipeline, and returns one result beat
// per input beat, in order. Between input and result lie an input register, three chains of 25
// division cells (tile size, tile number, source coordinate), two arithmetic stages and the
// output register. A stall on the result side holds the whole pipeline, so req_stall follows
// rsp_stall while a result waits.
module mosaic_tile_scale_addresser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mts_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mts_pkg::rsp_type       rsp_data,
   input  logic                   csr_wr_en,
   input  logic [mts_pkg::CsrW-1:0] csr_addr,
   input  logic [mts_pkg::DimW-1:0] csr_data
);

   logic [mts_pkg::GridW-1:0] cols_ff, rows_ff;
   logic [mts_pkg::PageW-1:0] page_ff;
   logic [mts_pkg::DimW-1:0]  ow_ff, oh_ff, sw_ff, sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= mts_pkg::GridW'(2);
         rows_ff <= mts_pkg::GridW'(2);
         page_ff <= '0;
         ow_ff   <= mts_pkg::DimW'(1280);
         oh_ff   <= mts_pkg::DimW'(720);
         sw_ff   <= mts_pkg::DimW'(640);
         sh_ff   <= mts_pkg::DimW'(360);
      end else if (csr_wr_en) begin
         case (mts_pkg::reg_index_type'(csr_addr))
            mts_pkg::REG_GRID_COLS:  cols_ff <= csr_data[mts_pkg::GridW-1:0];
            mts_pkg::REG_GRID_ROWS:  rows_ff <= csr_data[mts_pkg::GridW-1:0];
            mts_pkg::REG_START_PAGE: page_ff <= csr_data[mts_pkg::PageW-1:0];
            mts_pkg::REG_OUT_WIDTH:  ow_ff   <= csr_data;
            mts_pkg::REG_OUT_HEIGHT: oh_ff   <= csr_data;
            mts_pkg::REG_SRC_WIDTH:  sw_ff   <= csr_data;
            mts_pkg::REG_SRC_HEIGHT: sh_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic [mts_pkg::GridW-1:0] cols_c, rows_c;
   logic [mts_pkg::DimW-1:0]  ow_c, oh_c, sw_c, sh_c;

   assign cols_c = mts_pkg::clamp_grid(cols_ff);
   assign rows_c = mts_pkg::clamp_grid(rows_ff);
   assign ow_c   = mts_pkg::clamp_dim(ow_ff);
   assign oh_c   = mts_pkg::clamp_dim(oh_ff);
   assign sw_c   = mts_pkg::clamp_dim(sw_ff);
   assign sh_c   = mts_pkg::clamp_dim(sh_ff);

   logic adv;
   logic rsp_valid_ff;
   mts_pkg::rsp_type rsp_ff, rsp_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   mts_pkg::ctx_type p0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff.valid <= req_valid;
         p0_ff.out_x <= req_data.out_x;
         p0_ff.out_y <= req_data.out_y;
         p0_ff.mode  <= req_data.mode;
         p0_ff.col   <= '0;
         p0_ff.row   <= '0;
         p0_ff.rc    <= '0;
         p0_ff.frame <= '0;
      end
      if (reset) begin
         p0_ff.valid <= 1'b0;
      end
   end

   mts_pkg::pair_type pair_a_in, pair_a, pair_b_in, pair_b, pair_c;
   mts_pkg::ctx_type  ctx_a, ctx_b, ctx_c;
   logic [mts_pkg::DimW-1:0] tile_x, tile_y;

   always_comb begin
      pair_a_in.lx.rem     = '0;
      pair_a_in.lx.numq    = mts_pkg::NumW'(ow_c);
      pair_a_in.lx.divisor = mts_pkg::DimW'(cols_c);
      pair_a_in.ly.rem     = '0;
      pair_a_in.ly.numq    = mts_pkg::NumW'(oh_c);
      pair_a_in.ly.divisor = mts_pkg::DimW'(rows_c);
   end

   mts_div_chain u_chain_tile (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .ctx_i  (p0_ff),
      .pair_i (pair_a_in),
      .ctx_o  (ctx_a),
      .pair_o (pair_a)
   );

   always_comb begin
      tile_x = pair_a.lx.numq[mts_pkg::DimW-1:0];
      tile_y = pair_a.ly.numq[mts_pkg::DimW-1:0];
      if (ctx_a.mode) begin
         tile_x = tile_x >> 1;
         tile_y = tile_y >> 1;
      end
      if (tile_x == '0) tile_x = mts_pkg::DimW'(1);
      if (tile_y == '0) tile_y = mts_pkg::DimW'(1);
      pair_b_in.lx.rem     = '0;
      pair_b_in.lx.numq    = mts_pkg::NumW'(ctx_a.out_x);
      pair_b_in.lx.divisor = tile_x;
      pair_b_in.ly.rem     = '0;
      pair_b_in.ly.numq    = mts_pkg::NumW'(ctx_a.out_y);
      pair_b_in.ly.divisor = tile_y;
   end

   mts_div_chain u_chain_idx (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .ctx_i  (ctx_a),
      .pair_i (pair_b_in),
      .ctx_o  (ctx_b),
      .pair_o (pair_b)
   );

   logic [mts_pkg::GridW-1:0] cols_m1, rows_m1;
   logic [mts_pkg::IdxW-1:0]  idx_x, idx_y;
   logic [16:0]               base_x, base_y;
   mts_pkg::ctx_type          s1_ctx_ff, s1_ctx_in;
   logic [mts_pkg::PosW-1:0]  off_x_ff, off_y_ff, off_x_in, off_y_in;
   logic [mts_pkg::DimW-1:0]  tile_x_ff, tile_y_ff;

   always_comb begin
      cols_m1 = cols_c - mts_pkg::GridW'(1);
      rows_m1 = rows_c - mts_pkg::GridW'(1);
      idx_x = (pair_b.lx.numq > mts_pkg::NumW'(cols_m1)) ? cols_m1[mts_pkg::IdxW-1:0]
                                                        : pair_b.lx.numq[mts_pkg::IdxW-1:0];
      idx_y = (pair_b.ly.numq > mts_pkg::NumW'(rows_m1)) ? rows_m1[mts_pkg::IdxW-1:0]
                                                        : pair_b.ly.numq[mts_pkg::IdxW-1:0];
      base_x = 17'(idx_x) * 17'(pair_b.lx.divisor);
      base_y = 17'(idx_y) * 17'(pair_b.ly.divisor);
      off_x_in = ctx_b.out_x - base_x[mts_pkg::PosW-1:0];
      off_y_in = ctx_b.out_y - base_y[mts_pkg::PosW-1:0];
      s1_ctx_in     = ctx_b;
      s1_ctx_in.col = idx_x;
      s1_ctx_in.row = idx_y;
      s1_ctx_in.rc  = mts_pkg::RcW'(10'(rows_c) * 10'(cols_c));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctx_ff <= s1_ctx_in;
         off_x_ff  <= off_x_in;
         off_y_ff  <= off_y_in;
         tile_x_ff <= pair_b.lx.divisor;
         tile_y_ff <= pair_b.ly.divisor;
      end
      if (reset) begin
         s1_ctx_ff.valid <= 1'b0;
      end
   end

   mts_pkg::ctx_type  s2_ctx_ff, s2_ctx_in;
   mts_pkg::pair_type s2_pair_ff, s2_pair_in;
   logic [16:0]       page_part;
   logic [9:0]        row_part;

   always_comb begin
      page_part = 17'(page_ff) * 17'(s1_ctx_ff.rc);
      row_part  = 10'(s1_ctx_ff.row) * 10'(cols_c);
      s2_ctx_in       = s1_ctx_ff;
      s2_ctx_in.frame = mts_pkg::FrameW'(page_part + 17'(row_part) + 17'(s1_ctx_ff.col));
      s2_pair_in.lx.rem     = '0;
      s2_pair_in.lx.numq    = mts_pkg::NumW'(mts_pkg::half_src(sw_c, s1_ctx_ff.mode))
                              * mts_pkg::NumW'(off_x_ff);
      s2_pair_in.lx.divisor = tile_x_ff;
      s2_pair_in.ly.rem     = '0;
      s2_pair_in.ly.numq    = mts_pkg::NumW'(mts_pkg::half_src(sh_c, s1_ctx_ff.mode))
                              * mts_pkg::NumW'(off_y_ff);
      s2_pair_in.ly.divisor = tile_y_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctx_ff  <= s2_ctx_in;
         s2_pair_ff <= s2_pair_in;
      end
      if (reset) begin
         s2_ctx_ff.valid <= 1'b0;
      end
   end

   mts_div_chain u_chain_src (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .ctx_i  (s2_ctx_ff),
      .pair_i (s2_pair_ff),
      .ctx_o  (ctx_c),
      .pair_o (pair_c)
   );

   logic [mts_pkg::DimW-1:0] lim_x, lim_y;

   always_comb begin
      lim_x = mts_pkg::half_src(sw_c, ctx_c.mode) - mts_pkg::DimW'(1);
      lim_y = mts_pkg::half_src(sh_c, ctx_c.mode) - mts_pkg::DimW'(1);
      rsp_in.frame_index = ctx_c.frame;
      rsp_in.src_x = (pair_c.lx.numq > mts_pkg::NumW'(lim_x)) ? lim_x[mts_pkg::PosW-1:0]
                                                             : pair_c.lx.numq[mts_pkg::PosW-1:0];
      rsp_in.src_y = (pair_c.ly.numq > mts_pkg::NumW'(lim_y)) ? lim_y[mts_pkg::PosW-1:0]
                                                             : pair_c.ly.numq[mts_pkg::PosW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctx_c.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(ctx_c.valid))
      else $error("Pipeline moved while the result was stalled.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Stalled result beat was dropped.");

   a_tile_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctx_b.valid |-> (pair_b.lx.divisor != '0) && (pair_b.ly.divisor != '0))
      else $error("Tile size of zero reached the source stage.");

   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      s1_ctx_ff.valid |-> mts_pkg::GridW'(s1_ctx_ff.col) < cols_c)
      else $error("Tile column beyond the grid.");

endmodule

FILE: rtl/mts_cell.sv
// One restoring division step for the column and row lanes, with the beat context beside it.
module mts_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  mts_pkg::ctx_type  ctx_i,
   input  mts_pkg::pair_type pair_i,
   output mts_pkg::ctx_type  ctx_o,
   output mts_pkg::pair_type pair_o
);

   function automatic mts_pkg::lane_type step(input mts_pkg::lane_type l);
      logic [mts_pkg::DimW:0] sh;
      mts_pkg::lane_type      r;
      r  = l;
      sh = {l.rem, l.numq[mts_pkg::NumW-1]};
      if (sh >= {1'b0, l.divisor}) begin
         sh     = sh - {1'b0, l.divisor};
         r.numq = {l.numq[mts_pkg::NumW-2:0], 1'b1};
      end else begin
         r.numq = {l.numq[mts_pkg::NumW-2:0], 1'b0};
      end
      r.rem = sh[mts_pkg::DimW-1:0];
      return r;
   endfunction

   mts_pkg::ctx_type  ctx_ff;
   mts_pkg::pair_type pair_ff;
   mts_pkg::pair_type pair_in;

   always_comb begin
      pair_in.lx = step(pair_i.lx);
      pair_in.ly = step(pair_i.ly);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff  <= ctx_i;
         pair_ff <= pair_in;
      end
      if (reset) begin
         ctx_ff.valid <= 1'b0;
      end
   end

   assign ctx_o  = ctx_ff;
   assign pair_o = pair_ff;

endmodule

FILE: rtl/mts_div_chain.sv
// A row of division cells that turns a dividend into quotient and remainder, one bit per cell.
module mts_div_chain (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  mts_pkg::ctx_type  ctx_i,
   input  mts_pkg::pair_type pair_i,
   output mts_pkg::ctx_type  ctx_o,
   output mts_pkg::pair_type pair_o
);

   mts_pkg::ctx_type  ctx_w  [0:mts_pkg::Steps];
   mts_pkg::pair_type pair_w [0:mts_pkg::Steps];

   assign ctx_w[0]  = ctx_i;
   assign pair_w[0] = pair_i;

   for (genvar i = 0; i < mts_pkg::Steps; i++) begin : g_cell
      mts_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctx_i  (ctx_w[i]),
         .pair_i (pair_w[i]),
         .ctx_o  (ctx_w[i+1]),
         .pair_o (pair_w[i+1])
      );
   end

   assign ctx_o  = ctx_w[mts_pkg::Steps];
   assign pair_o = pair_w[mts_pkg::Steps];

endmodule
